@@ sv/pressure_temperature_compensation_top_assert.svh @@
// assertion macros for the compensation pipeline
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_TOP_ASSERT_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// condition that must hold at every clock edge outside reset
`define PTC_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);
// consequence that must hold in the cycle after the antecedent
`define PTC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PTC_ASSERT_ALWAYS(lbl, cond, msg)
`define PTC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ sv/ptc_pkg.sv @@
// shared constants and types for the compensation pipeline
package ptc_pkg;

    // configuration register indexes
    typedef enum logic [7:0] {
        CFG_TEMP    = 8'd0,
        CFG_PRESS_A = 8'd1,
        CFG_PRESS_B = 8'd2,
        CFG_PRESS_C = 8'd3
    } t_cfg_idx;

    // output ranges in 1/65536 units
    localparam logic signed [24:0] T_MIN = -25'sd4259840;
    localparam logic signed [24:0] T_MAX = 25'sd9830400;
    localparam logic [26:0]        P_MAX = 27'd81920000;

    // pressure rounding: floor((N / 2^164 + 100) / 200)
    localparam int               PA_SHIFT = 164;
    localparam int               PA_HALF  = 100;
    // smallest quotient input that exceeds the pressure range, 200 * (P_MAX + 1)
    localparam logic [35:0]      P_LIM    = 36'd16384000200;
    // reciprocal of 25 scaled by 2^36, exact for 31-bit dividends
    localparam logic [31:0]      RECIP_M  = 32'd2748779070;
    localparam int               RECIP_SH = 36;

endpackage

@@ sv/ptc_mul.sv @@
// pipelined signed multiply-accumulate built from 32-bit partial products
module ptc_mul #(
    parameter int AW = 32,
    parameter int BW = 32,
    parameter int RW = 64
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [AW-1:0] i_a,
    input  logic signed [BW-1:0] i_b,
    input  logic signed [RW-1:0] i_c,
    output logic signed [RW-1:0] o_y
);
    localparam int CW  = 32;
    localparam int NA  = (AW + CW - 1) / CW;
    localparam int NB  = (BW + CW - 1) / CW;
    localparam int AXW = NA * CW;
    localparam int BXW = NB * CW;
    localparam int PW  = 2 * CW + 2;

    logic signed [AXW-1:0] w_a_ext;
    logic signed [BXW-1:0] w_b_ext;
    logic signed [PW-1:0]  w_pp [NA*NB];
    logic signed [PW-1:0]  r_pp [NA*NB];
    logic signed [RW-1:0]  w_row [NB];
    logic signed [RW-1:0]  r_row [NB];
    logic signed [RW-1:0]  r_c1;
    logic signed [RW-1:0]  r_c2;
    logic signed [RW-1:0]  w_sum;
    logic signed [RW-1:0]  r_y;

    assign w_a_ext = AXW'(i_a);
    assign w_b_ext = BXW'(i_b);

    // digit products: low digits unsigned, top digit carries the sign
    always_comb begin
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                w_pp[i*NB+j] =
                    $signed({(i == NA - 1) ? w_a_ext[i*CW+CW-1] : 1'b0, w_a_ext[i*CW +: CW]}) *
                    $signed({(j == NB - 1) ? w_b_ext[j*CW+CW-1] : 1'b0, w_b_ext[j*CW +: CW]});
            end
        end
    end

    // one row per digit of b
    always_comb begin
        for (int j = 0; j < NB; j++) begin
            w_row[j] = '0;
            for (int i = 0; i < NA; i++) begin
                w_row[j] = w_row[j] + (RW'(r_pp[i*NB+j]) <<< (i * CW));
            end
        end
    end

    // rows plus addend
    always_comb begin
        w_sum = r_c2;
        for (int j = 0; j < NB; j++) begin
            w_sum = w_sum + (r_row[j] <<< (j * CW));
        end
    end

    // three register stages, all held on stall
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pp  <= w_pp;
            r_c1  <= i_c;
            r_row <= w_row;
            r_c2  <= r_c1;
            r_y   <= w_sum;
        end
    end

    assign o_y = r_y;

endmodule

@@ sv/ptc_dly.sv @@
// enabled shift register that keeps side values in step with the pipeline
module ptc_dly #(
    parameter int W = 8,
    parameter int N = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);
    logic [W-1:0] r_tap [N];

    // shift on each pipeline advance
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tap[0] <= i_d;
            for (int k = 1; k < N; k++) begin
                r_tap[k] <= r_tap[k-1];
            end
        end
    end

    assign o_q = r_tap[N-1];

endmodule

@@ sv/pressure_temperature_compensation_top.sv @@
// barometric temperature and pressure compensation pipeline, top level
//
//  channel   direction  signals                              payload
//  s         in         i_s_tvalid o_s_tready i_s_tdata     raw temperature, raw pressure
//  m         out        o_m_tvalid i_m_tready o_m_tdata      temperature, pressure
//                       o_m_tuser                            saturation flag
//  cfg       in         i_cfg_valid o_cfg_ready              register index and data
//
//  one sample pair per cycle while the output is not stalled; the path is capture plus
//  two setup stages, four chained multiply-accumulates (linearized temperature, three
//  Horner steps), then four rounding and divide stages
//  synchronous active-low reset clears stage valids and coefficients
//  a stalled output freezes every stage, so nothing is dropped or repeated
//  configuration is always ready and takes effect at once
`include "pressure_temperature_compensation_top_assert.svh"

module pressure_temperature_compensation_top
    import ptc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,    // raw_temperature [23:0], raw_pressure [47:24]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata,    // temperature_out [24:0], pressure_out [51:25], zero
    output logic        o_m_tuser,    // saturated [0]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data
);
    localparam int NST = 19;

    logic [39:0] r_cfg_temp;
    logic [47:0] r_cfg_pa;
    logic [47:0] r_cfg_pb;
    logic [31:0] r_cfg_pc;

    logic [NST-1:0] r_vld;
    logic           w_en;

    // coefficient fields
    logic [15:0]        w_t1, w_t2, w_p5, w_p6;
    logic signed [7:0]  w_t3, w_p3, w_p4, w_p7, w_p8, w_p10, w_p11;
    logic signed [15:0] w_p1, w_p2, w_p9;
    logic signed [16:0] w_p1m, w_p2m;

    logic [23:0]        r_s0_rt, r_s0_rp;
    logic signed [24:0] w_d, w_rs;
    logic signed [33:0] w_g2, w_k2, w_k3;
    logic signed [36:0] w_f2;
    logic signed [24:0] r_s1_d, r_s1_r;
    logic signed [33:0] r_s1_g2, r_s1_k2, r_s1_k3;
    logic signed [36:0] r_s1_f2;
    logic signed [35:0] w_e, r_s2_e;
    logic signed [24:0] r_s2_d;

    logic signed [62:0]  w_g1;
    logic signed [61:0]  w_f1;
    logic [24:0]         w_r4;
    logic signed [87:0]  w_g0;
    logic signed [60:0]  w_tl;
    logic [33:0]         w_k3_5, w_k2_5;
    logic signed [95:0]  w_h2;
    logic [60:0]         w_tl8, w_tl11;
    logic [61:0]         w_f1_8;
    logic signed [157:0] w_h1;
    logic [87:0]         w_g0_11;
    logic signed [219:0] w_h0;

    logic signed [61:0] w_tr;
    logic signed [29:0] w_tq;
    logic signed [24:0] w_tc;
    logic               w_tsat;
    logic signed [24:0] r_s6_temp;
    logic               r_s6_tsat;
    logic [25:0]        w_t17;

    logic signed [219:0] w_n;
    logic                r_s15_neg;
    logic [55:0]         r_s15_f;
    logic                r_s16_neg, r_s16_over;
    logic [30:0]         r_s16_g;
    logic [62:0]         w_prod;
    logic [62:0]         r_s17_prod;
    logic                r_s17_neg, r_s17_over;
    logic [26:0]         w_pq;

    logic signed [24:0] r_out_temp;
    logic [26:0]        r_out_press;
    logic               r_out_sat;

    // configuration writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_temp <= '0;
            r_cfg_pa   <= '0;
            r_cfg_pb   <= '0;
            r_cfg_pc   <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TEMP:    r_cfg_temp <= i_cfg_data[39:0];
                CFG_PRESS_A: r_cfg_pa   <= i_cfg_data;
                CFG_PRESS_B: r_cfg_pb   <= i_cfg_data;
                CFG_PRESS_C: r_cfg_pc   <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // unpack coefficients
    assign w_t1  = r_cfg_temp[15:0];
    assign w_t2  = r_cfg_temp[31:16];
    assign w_t3  = $signed(r_cfg_temp[39:32]);
    assign w_p1  = $signed(r_cfg_pa[15:0]);
    assign w_p2  = $signed(r_cfg_pa[31:16]);
    assign w_p3  = $signed(r_cfg_pa[39:32]);
    assign w_p4  = $signed(r_cfg_pa[47:40]);
    assign w_p5  = r_cfg_pb[15:0];
    assign w_p6  = r_cfg_pb[31:16];
    assign w_p7  = $signed(r_cfg_pb[39:32]);
    assign w_p8  = $signed(r_cfg_pb[47:40]);
    assign w_p9  = $signed(r_cfg_pc[15:0]);
    assign w_p10 = $signed(r_cfg_pc[23:16]);
    assign w_p11 = $signed(r_cfg_pc[31:24]);
    assign w_p1m = 17'(w_p1) - 17'sd16384;
    assign w_p2m = 17'(w_p2) - 17'sd16384;

    // pipeline advance: whole pipe moves unless the output holds an untaken result
    assign w_en       = !r_vld[NST-1] || i_m_tready;
    assign o_s_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NST-2:0], i_s_tvalid};
        end
    end

    // stage 0: capture request
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_rt <= i_s_tdata[23:0];
            r_s0_rp <= i_s_tdata[47:24];
        end
    end

    // stage 1: offset temperature and first Horner steps in raw pressure
    assign w_d  = $signed({1'b0, r_s0_rt}) - $signed({1'b0, w_t1, 8'h00});
    assign w_rs = $signed({1'b0, r_s0_rp});
    assign w_g2 = (34'(w_p9) <<< 17) + 34'(w_rs * w_p11);
    assign w_f2 = (37'(w_p2m) <<< 19) + 37'(w_rs * w_p10);
    assign w_k2 = (34'(w_p7) <<< 24) + 34'(w_rs * w_p3);
    assign w_k3 = (34'(w_p8) <<< 22) + 34'(w_rs * w_p4);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_d  <= w_d;
            r_s1_r  <= w_rs;
            r_s1_g2 <= w_g2;
            r_s1_f2 <= w_f2;
            r_s1_k2 <= w_k2;
            r_s1_k3 <= w_k3;
        end
    end

    // stage 2: temperature slope term e = T2*2^18 + d*T3
    assign w_e = (36'($signed({1'b0, w_t2})) <<< 18) + 36'(r_s1_d * w_t3);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_e <= w_e;
            r_s2_d <= r_s1_d;
        end
    end

    // raw pressure polynomials (stages 4 and 7)
    ptc_mul #(.AW(25), .BW(34), .RW(63)) u_mul_g1 (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_s1_r), .i_b(r_s1_g2),
        .i_c(63'(w_p1m) <<< 45), .o_y(w_g1)
    );

    ptc_mul #(.AW(25), .BW(37), .RW(62)) u_mul_f1 (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_s1_r), .i_b(r_s1_f2),
        .i_c(62'($signed({1'b0, w_p6})) <<< 42), .o_y(w_f1)
    );

    ptc_dly #(.W(25), .N(3)) u_dly_r (
        .i_clk(i_clk), .i_en(w_en), .i_d(r_s1_r), .o_q(w_r4)
    );

    ptc_mul #(.AW(25), .BW(63), .RW(88)) u_mul_g0 (
        .i_clk(i_clk), .i_en(w_en), .i_a($signed(w_r4)), .i_b(w_g1),
        .i_c(88'($signed({1'b0, w_p5})) <<< 68), .o_y(w_g0)
    );

    // linearized temperature times 2^48 (stage 5)
    ptc_mul #(.AW(25), .BW(36), .RW(61)) u_mul_tl (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_s2_d), .i_b(r_s2_e),
        .i_c('0), .o_y(w_tl)
    );

    ptc_dly #(.W(34), .N(4)) u_dly_k3 (
        .i_clk(i_clk), .i_en(w_en), .i_d(r_s1_k3), .o_q(w_k3_5)
    );

    ptc_dly #(.W(34), .N(4)) u_dly_k2 (
        .i_clk(i_clk), .i_en(w_en), .i_d(r_s1_k2), .o_q(w_k2_5)
    );

    // Horner in temperature, step one (stage 8)
    ptc_mul #(.AW(34), .BW(61), .RW(96)) u_mul_h2 (
        .i_clk(i_clk), .i_en(w_en), .i_a($signed(w_k3_5)), .i_b(w_tl),
        .i_c(96'($signed(w_k2_5)) <<< 53), .o_y(w_h2)
    );

    ptc_dly #(.W(61), .N(3)) u_dly_tl8 (
        .i_clk(i_clk), .i_en(w_en), .i_d(w_tl), .o_q(w_tl8)
    );

    ptc_dly #(.W(62), .N(4)) u_dly_f1 (
        .i_clk(i_clk), .i_en(w_en), .i_d(w_f1), .o_q(w_f1_8)
    );

    // Horner step two (stage 11)
    ptc_mul #(.AW(96), .BW(61), .RW(158)) u_mul_h1 (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_h2), .i_b($signed(w_tl8)),
        .i_c(158'($signed(w_f1_8)) <<< 85), .o_y(w_h1)
    );

    ptc_dly #(.W(61), .N(3)) u_dly_tl11 (
        .i_clk(i_clk), .i_en(w_en), .i_d(w_tl8), .o_q(w_tl11)
    );

    ptc_dly #(.W(88), .N(4)) u_dly_g0 (
        .i_clk(i_clk), .i_en(w_en), .i_d(w_g0), .o_q(w_g0_11)
    );

    // Horner step three: pressure in Pa times 2^181 (stage 14)
    ptc_mul #(.AW(158), .BW(61), .RW(220)) u_mul_h0 (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_h1), .i_b($signed(w_tl11)),
        .i_c(220'($signed(w_g0_11)) <<< 116), .o_y(w_h0)
    );

    // stage 6: temperature rounding and clamp
    assign w_tr = 62'(w_tl) + (62'sd1 <<< 31);
    assign w_tq = $signed(w_tr[61:32]);

    always_comb begin
        w_tc   = w_tq[24:0];
        w_tsat = 1'b0;
        priority if (w_tq < 30'(T_MIN)) begin
            w_tc   = T_MIN;
            w_tsat = 1'b1;
        end else if (w_tq > 30'(T_MAX)) begin
            w_tc   = T_MAX;
            w_tsat = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s6_temp <= w_tc;
            r_s6_tsat <= w_tsat;
        end
    end

    ptc_dly #(.W(26), .N(11)) u_dly_temp (
        .i_clk(i_clk), .i_en(w_en), .i_d({r_s6_tsat, r_s6_temp}), .o_q(w_t17)
    );

    // stage 15: add half unit and drop fraction
    assign w_n = w_h0 + (220'(PA_HALF) <<< PA_SHIFT);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s15_neg <= w_n[219];
            r_s15_f   <= w_n[219:PA_SHIFT];
        end
    end

    // stage 16: range check and divide by 8
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s16_neg  <= r_s15_neg;
            r_s16_over <= (r_s15_f >= 56'(P_LIM));
            r_s16_g    <= r_s15_f[33:3];
        end
    end

    // stage 17: divide by 25 via reciprocal
    assign w_prod = r_s16_g * RECIP_M;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s17_prod <= w_prod;
            r_s17_neg  <= r_s16_neg;
            r_s17_over <= r_s16_over;
        end
    end

    // stage 18: pressure clamp and output register
    always_comb begin
        priority if (r_s17_neg) begin
            w_pq = '0;
        end else if (r_s17_over) begin
            w_pq = P_MAX;
        end else begin
            w_pq = r_s17_prod[RECIP_SH +: 27];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_temp  <= $signed(w_t17[24:0]);
            r_out_press <= w_pq;
            r_out_sat   <= w_t17[25] || r_s17_neg || r_s17_over;
        end
    end

    assign o_m_tvalid = r_vld[NST-1];
    assign o_m_tdata  = {4'b0000, r_out_press, r_out_temp};
    assign o_m_tuser  = r_out_sat;

    // checks
    `PTC_ASSERT_ALWAYS(a_press_range, !o_m_tvalid || (r_out_press <= P_MAX),
        "pressure out of range")
    `PTC_ASSERT_ALWAYS(a_temp_range,
        !o_m_tvalid || ((r_out_temp >= T_MIN) && (r_out_temp <= T_MAX)),
        "temperature out of range")
    `PTC_ASSERT_NEXT(a_stall_hold, o_m_tvalid && !i_m_tready, $stable(r_vld),
        "pipeline moved while stalled")
    `PTC_ASSERT_NEXT(a_neg_clamp, r_vld[NST-2] && w_en && r_s17_neg,
        (r_out_press == '0) && r_out_sat, "negative pressure not clamped")

endmodule

@@ dv/ptc_checker.sv @@
// checker for the compensation pipeline: predicts each result and compares it
`timescale 1ns / 1ps

module ptc_checker
    import ptc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [47:0] i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [55:0] i_m_tdata,
    input  logic        i_m_tuser,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending,
    output int          o_checked,
    output int          o_sat_seen
);

    typedef struct packed {
        logic signed [24:0] temp;
        logic [26:0]        press;
        logic               sat;
    } t_reading;

    logic [39:0] coef_t;
    logic [47:0] coef_a;
    logic [47:0] coef_b;
    logic [31:0] coef_c;

    t_reading expected_readings[$];

    assign o_pending = expected_readings.size();

    // one line per mismatch, and count it
    task automatic report_mismatch(input string what, input longint got, input longint want);
        o_errors++;
        $display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    // exact fixed-point compensation of one raw sample pair
    function automatic t_reading compensate(input logic [23:0] raw_t, input logic [23:0] raw_p);
        t_reading           res;
        longint             t1c, t2c, t3c, diff, tlin, tq;
        longint             p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11;
        logic signed [255:0] tv1, tv2, tv3, rv1, rv2, rv3, acc, quo;
        logic signed [255:0] k1, k2, k3, k4, k5, k6, k7, k8, k9, k10, k11;
        logic [63:0]        pq;
        t1c = coef_t[15:0];
        t2c = coef_t[31:16];
        t3c = $signed(coef_t[39:32]);
        p1  = $signed(coef_a[15:0]);
        p2  = $signed(coef_a[31:16]);
        p3  = $signed(coef_a[39:32]);
        p4  = $signed(coef_a[47:40]);
        p5  = coef_b[15:0];
        p6  = coef_b[31:16];
        p7  = $signed(coef_b[39:32]);
        p8  = $signed(coef_b[47:40]);
        p9  = $signed(coef_c[15:0]);
        p10 = $signed(coef_c[23:16]);
        p11 = $signed(coef_c[31:24]);
        res.sat = 1'b0;

        // linearized temperature over 2^48
        diff = longint'(raw_t) - t1c * 256;
        tlin = diff * t2c * 262144 + diff * diff * t3c;
        tq   = (tlin + (64'sd1 <<< 31)) >>> 32;
        if (tq < T_MIN) begin
            tq = T_MIN;
            res.sat = 1'b1;
        end
        if (tq > T_MAX) begin
            tq = T_MAX;
            res.sat = 1'b1;
        end
        res.temp = tq[24:0];

        // pressure in Pa over 2^181
        tv1 = tlin;
        tv2 = tv1 * tv1;
        tv3 = tv2 * tv1;
        rv1 = longint'(raw_p);
        rv2 = rv1 * rv1;
        rv3 = rv2 * rv1;
        k1 = p1 - 16384; k2 = p2 - 16384; k3 = p3; k4 = p4; k5 = p5; k6 = p6;
        k7 = p7; k8 = p8; k9 = p9; k10 = p10; k11 = p11;
        acc = k5 <<< 184;
        acc = acc + ((tv1 * k6) <<< 127);
        acc = acc + ((tv2 * k7) <<< 77);
        acc = acc + ((tv3 * k8) <<< 22);
        acc = acc + ((rv1 * k1) <<< 161);
        acc = acc + (((rv1 * tv1) * k2) <<< 104);
        acc = acc + (((rv1 * tv2) * k3) <<< 53);
        acc = acc + ((rv1 * tv3) * k4);
        acc = acc + ((rv2 * k9) <<< 133);
        acc = acc + (((rv2 * tv1) * k10) <<< 85);
        acc = acc + ((rv3 * k11) <<< 116);
        acc = acc + (256'sd100 <<< 164);

        // round to 1/65536 hPa and clamp
        if (acc[255]) begin
            pq = 0;
            res.sat = 1'b1;
        end else begin
            quo = acc >> 164;
            if (quo[255:64] != 0) pq = 64'(P_MAX) + 1;
            else pq = quo[63:0] / 200;
            if (pq > P_MAX) begin
                pq = P_MAX;
                res.sat = 1'b1;
            end
        end
        res.press = pq[26:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_reading got, want;
        if (!i_rst_n) begin
            coef_t <= '0;
            coef_a <= '0;
            coef_b <= '0;
            coef_c <= '0;
            expected_readings.delete();
            o_errors    = 0;
            o_checked  <= 0;
            o_sat_seen <= 0;
        end else begin
            // register writes
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_TEMP:    coef_t <= i_cfg_data[39:0];
                    CFG_PRESS_A: coef_a <= i_cfg_data;
                    CFG_PRESS_B: coef_b <= i_cfg_data;
                    CFG_PRESS_C: coef_c <= i_cfg_data[31:0];
                    default: ;
                endcase
            end
            // accepted request
            if (i_s_tvalid && i_s_tready)
                expected_readings.push_back(compensate(i_s_tdata[23:0], i_s_tdata[47:24]));
            // accepted result
            if (i_m_tvalid && i_m_tready) begin
                got.temp  = i_m_tdata[24:0];
                got.press = i_m_tdata[51:25];
                got.sat   = i_m_tuser;
                if (expected_readings.size() == 0) begin
                    report_mismatch("result with nothing pending", 1, 0);
                end else begin
                    want = expected_readings.pop_front();
                    o_checked <= o_checked + 1;
                    if (want.sat) o_sat_seen <= o_sat_seen + 1;
                    if (got.temp !== want.temp)
                        report_mismatch("temperature_out", got.temp, want.temp);
                    if (got.press !== want.press)
                        report_mismatch("pressure_out", got.press, want.press);
                    if (got.sat !== want.sat)
                        report_mismatch("saturated", got.sat, want.sat);
                end
            end
        end
    end

endmodule

@@ dv/tb_pressure_temperature_compensation_top.sv @@
// testbench top: stimulus, handshake idling and verdict for the compensation pipeline
`timescale 1ns / 1ps

module tb_pressure_temperature_compensation_top;
    import ptc_pkg::*;

    localparam int PIPE_LAT  = 19;
    localparam int MAX_CYCLE = 2000000;
    localparam int N_SETS    = 6;
    localparam int PER_SET   = 175;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [47:0] i_s_tdata;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [55:0] o_m_tdata;
    logic        o_m_tuser;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index;
    logic [47:0] i_cfg_data;

    int errors, pending, checked, sat_seen;
    int send_idle_pct, recv_stall_pct;
    int cycle_cnt = 0;

    pressure_temperature_compensation_top u_dut (.*);

    ptc_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .i_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_m_tdata   (o_m_tdata),
        .i_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_sat_seen  (sat_seen)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > MAX_CYCLE) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver stalls
    always @(negedge i_clk)
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // one request on the sample channel, with random idle cycles first
    task automatic send_sample(input logic [23:0] raw_t, input logic [23:0] raw_p);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {raw_p, raw_t};
        do @(posedge i_clk); while (!(i_s_tvalid && o_s_tready));
        @(negedge i_clk);
    endtask

    // let the pipeline empty out, then a register write is safe
    task automatic drain;
        i_s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (PIPE_LAT + 6) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [47:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic load_coeffs(input logic [47:0] ct, input logic [47:0] ca,
                               input logic [47:0] cb, input logic [47:0] cc);
        drain();
        write_reg(CFG_TEMP, ct);
        write_reg(CFG_PRESS_A, ca);
        write_reg(CFG_PRESS_B, cb);
        write_reg(CFG_PRESS_C, cc);
    endtask

    function automatic logic [47:0] rand48();
        return {16'($urandom_range(16'hffff)), $urandom()};
    endfunction

    initial begin
        logic [15:0] tref;
        logic [23:0] rt, rp;
        i_rst_n        = 1'b0;
        i_s_tvalid     = 1'b0;
        i_s_tdata      = '0;
        i_m_tready     = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = CFG_TEMP;
        i_cfg_data     = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset coefficients, corner raw values
        send_sample(24'h000000, 24'h000000);
        send_sample(24'hffffff, 24'hffffff);
        send_sample(24'h000000, 24'hffffff);
        send_sample(24'hffffff, 24'h000000);

        // typical calibration set
        load_coeffs(48'h00_f6_4a_68_6b, 48'h06_07_b8_8f_f5_70, 48'hfa_0c_42_1c_4d_e4,
                    48'h00_00_f1_0d_46_c9);
        send_sample(24'h6b_00_00, 24'h70_00_00);
        send_sample(24'h6b_4a_00, 24'h6a_12_34);
        send_sample(24'h80_00_00, 24'h80_00_00);
        send_sample(24'h000000, 24'h000000);
        send_sample(24'hffffff, 24'hffffff);
        send_sample(24'h555555, 24'haaaaaa);
        send_sample(24'haaaaaa, 24'h555555);

        // all-ones coefficients, and writes to unused indexes that must be ignored
        load_coeffs('1, '1, '1, '1);
        write_reg(t_cfg_idx'(8'd4), 48'h0);
        write_reg(t_cfg_idx'(8'hff), 48'h0);
        send_sample(24'h000000, 24'h000000);
        send_sample(24'hffffff, 24'hffffff);
        send_sample(24'hffff00, 24'h000001);

        // most negative signed coefficients, largest unsigned but for T1, which is zero
        load_coeffs(48'h00_80_ff_ff_00_00, 48'h80_80_80_00_80_00, 48'h80_80_ff_ff_ff_ff,
                    48'h00_00_80_80_80_00);
        send_sample(24'h000000, 24'hffffff);
        send_sample(24'hffffff, 24'h000000);
        send_sample(24'h7fffff, 24'h800000);

        // random phases: each pair of coefficient sets shares an idling profile
        for (int s = 0; s < N_SETS; s++) begin
            case (s / 2)
                0: begin send_idle_pct = 33; recv_stall_pct = 73; end
                1: begin send_idle_pct = 73; recv_stall_pct = 33; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            load_coeffs(rand48(), rand48(), rand48(), rand48());
            tref = 16'($urandom_range(16'hffff));
            if (s % 2 == 0) begin
                // a plausible calibration keeps most results inside the range
                load_coeffs({8'h00, 8'($urandom_range(2, 250)), 16'($urandom_range(15000, 22000)),
                             tref}, rand48(), rand48(), rand48());
            end
            for (int k = 0; k < PER_SET; k++) begin
                if ($urandom_range(3) != 0)
                    rt = {tref, 8'h00} + 24'($urandom_range(16'hffff)) - 24'h8000;
                else
                    rt = 24'($urandom_range(24'hffffff));
                rp = 24'($urandom_range(24'hffffff));
                send_sample(rt, rp);
            end
        end

        // wait for the last results
        i_s_tvalid <= 1'b0;
        recv_stall_pct = 0;
        while (pending != 0) @(negedge i_clk);
        repeat (PIPE_LAT + 10) @(negedge i_clk);

        $display("checked %0d results, %0d of them clamped, over %0d coefficient sets",
                 checked, sat_seen, N_SETS + 4);
        if (errors == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
